// ----- rtl/signed_divider_regs_assert.svh -----
// Assertion macros shared by the signed divider register block.
`ifndef SIGNED_DIVIDER_REGS_ASSERT_SVH
`define SIGNED_DIVIDER_REGS_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every clock edge outside reset.
`define SDR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("signed divider: implication failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define SDR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("signed divider: next-cycle implication failed");
`else
`define SDR_ASSERT_IMPL(label, ante, cons)
`define SDR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/sdr_pkg.sv -----
// Shared types, register codes and helpers of the signed divider block.
`timescale 1ns / 1ps
package sdr_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned WideWidth = 64;
   localparam int unsigned CountWidth = 6;

   // Register selector codes.
   localparam logic [3:0] SEL_CTRL   = 4'd0;
   localparam logic [3:0] SEL_NUM_LO = 4'd1;
   localparam logic [3:0] SEL_NUM_HI = 4'd2;
   localparam logic [3:0] SEL_DEN_LO = 4'd3;
   localparam logic [3:0] SEL_DEN_HI = 4'd4;
   localparam logic [3:0] SEL_QUO_LO = 4'd5;
   localparam logic [3:0] SEL_QUO_HI = 4'd6;
   localparam logic [3:0] SEL_REM_LO = 4'd7;
   localparam logic [3:0] SEL_REM_HI = 4'd8;

   // Access codes.
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Divide modes.
   localparam logic [1:0] MODE_32_32 = 2'd0;
   localparam logic [1:0] MODE_64_64 = 2'd2;

   localparam logic [WideWidth-1:0] MOST_NEGATIVE = {1'b1, {(WideWidth-1){1'b0}}};
   localparam logic [WideWidth-1:0] ALL_ONES = {WideWidth{1'b1}};
   localparam logic [WideWidth-1:0] PLUS_ONE = {{(WideWidth-1){1'b0}}, 1'b1};

   // Completion of one divide, handed from the divider unit to the registers.
   typedef struct packed {
      logic                 valid;
      logic                 quot_we;
      logic                 rem_we;
      logic                 zero_div;
      logic [WideWidth-1:0] quot;
      logic [WideWidth-1:0] rem;
   } sdr_result_type;

   // Merges new data into one 32-bit half under a per-bit write enable.
   function automatic logic [DataWidth-1:0] merge_bits(
      input logic [DataWidth-1:0] old_bits,
      input logic [DataWidth-1:0] new_bits,
      input logic [DataWidth-1:0] enable_bits
   );
      merge_bits = (old_bits & ~enable_bits) | (new_bits & enable_bits);
   endfunction

   // Sign-extends the low half of a 64-bit value.
   function automatic logic [WideWidth-1:0] sext_low(input logic [WideWidth-1:0] value);
      sext_low = {{DataWidth{value[DataWidth-1]}}, value[DataWidth-1:0]};
   endfunction

endpackage

// ----- rtl/sdr_core.sv -----
// Iterative signed divider: one restoring subtract step per quotient bit.
`timescale 1ns / 1ps
module sdr_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                mode,
   input  logic [63:0]               dividend,
   input  logic [63:0]               divisor,
   output logic                      busy,
   output sdr_pkg::sdr_result_type   result
);
   import sdr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ITER,
      ST_FIX
   } state_type;

   state_type                state_ff;
   logic [WideWidth-1:0]     n_ff;
   logic [WideWidth-1:0]     d_ff;
   logic [WideWidth-1:0]     q_ff;
   logic [WideWidth-1:0]     ud_ff;
   logic [WideWidth-1:0]     rem_ff;
   logic [CountWidth-1:0]    count_ff;
   logic                     nneg_ff;
   logic                     qneg_ff;
   sdr_result_type           result_ff;

   logic [WideWidth-1:0]     n_in;
   logic [WideWidth-1:0]     d_in;
   logic [WideWidth:0]       shifted;
   logic [WideWidth:0]       diff;

   // Operand widening by mode.
   always_comb begin
      n_in = (mode == MODE_32_32) ? sext_low(dividend) : dividend;
      d_in = (mode == MODE_64_64) ? divisor : sext_low(divisor);
   end

   // One restoring step: shift in the next numerator bit and try the subtract.
   always_comb begin
      shifted = {rem_ff, q_ff[WideWidth-1]};
      diff    = shifted - {1'b0, ud_ff};
   end

   assign busy   = (state_ff != ST_IDLE);
   assign result = result_ff;

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      result_ff.valid <= 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_ff     <= n_in;
               d_ff     <= d_in;
               state_ff <= ST_CHECK;
            end
         end
         ST_CHECK: begin
            nneg_ff  <= n_ff[WideWidth-1];
            qneg_ff  <= n_ff[WideWidth-1] ^ d_ff[WideWidth-1];
            if (d_ff == '0) begin
               // Divide by zero: quotient is one against the numerator sign.
               result_ff.valid    <= 1'b1;
               result_ff.quot_we  <= 1'b1;
               result_ff.rem_we   <= 1'b1;
               result_ff.zero_div <= 1'b1;
               result_ff.quot     <= n_ff[WideWidth-1] ? PLUS_ONE : ALL_ONES;
               result_ff.rem      <= n_ff;
               state_ff           <= ST_IDLE;
            end else if (n_ff == MOST_NEGATIVE && d_ff == ALL_ONES) begin
               // Overflow: the remainder keeps its old value.
               result_ff.valid    <= 1'b1;
               result_ff.quot_we  <= 1'b1;
               result_ff.rem_we   <= 1'b0;
               result_ff.zero_div <= 1'b0;
               result_ff.quot     <= MOST_NEGATIVE;
               state_ff           <= ST_IDLE;
            end else begin
               q_ff     <= n_ff[WideWidth-1] ? (WideWidth'(0) - n_ff) : n_ff;
               ud_ff    <= d_ff[WideWidth-1] ? (WideWidth'(0) - d_ff) : d_ff;
               rem_ff   <= '0;
               count_ff <= '0;
               state_ff <= ST_ITER;
            end
         end
         ST_ITER: begin
            if (!diff[WideWidth]) begin
               rem_ff <= diff[WideWidth-1:0];
               q_ff   <= {q_ff[WideWidth-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[WideWidth-1:0];
               q_ff   <= {q_ff[WideWidth-2:0], 1'b0};
            end
            count_ff <= count_ff + 1'b1;
            if (count_ff == {CountWidth{1'b1}}) begin
               state_ff <= ST_FIX;
            end
         end
         ST_FIX: begin
            // Signs back on: quotient by both signs, remainder by the numerator.
            result_ff.valid    <= 1'b1;
            result_ff.quot_we  <= 1'b1;
            result_ff.rem_we   <= 1'b1;
            result_ff.zero_div <= 1'b0;
            result_ff.quot     <= qneg_ff ? (WideWidth'(0) - q_ff) : q_ff;
            result_ff.rem      <= nneg_ff ? (WideWidth'(0) - rem_ff) : rem_ff;
            state_ff           <= ST_IDLE;
         end
         default: begin
            state_ff <= ST_IDLE;
         end
      endcase
      if (reset) begin
         state_ff        <= ST_IDLE;
         result_ff.valid <= 1'b0;
      end
   end

endmodule

// ----- rtl/signed_divider_regs.sv -----
// Top level: register file, bus handshake and response register of the divider.
`timescale 1ns / 1ps
// A memory-mapped signed divider reached one 32-bit register half per beat. A read
// beat returns its data in the cycle after acceptance. A write to control, numerator or
// denominator returns a zero beat in the cycle after acceptance and starts a divide in
// the subtract unit: a start step, a check step, one restoring step per quotient bit,
// a sign-fix step and a write-back step. The next beat is taken only after the result
// is written back, also for a zero divisor or the overflow case.
// While the divide runs no new beat is accepted, so every read sees finished results.
// Writes to quotient, remainder or unused selectors are dropped and start no divide.
module signed_divider_regs (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [3:0]  req_reg_select,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_bit_mask,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data
);
   import sdr_pkg::*;

   logic [1:0]           div_mode_ff;
   logic [WideWidth-1:0] dividend_ff;
   logic [WideWidth-1:0] divisor_ff;
   logic [WideWidth-1:0] quot_ff;
   logic [WideWidth-1:0] rem_ff;
   logic                 zero_div_ff;
   logic                 start_ff;
   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] rsp_data_ff;

   logic [1:0]           div_mode_in;
   logic [WideWidth-1:0] dividend_in;
   logic [WideWidth-1:0] divisor_in;
   logic                 start_in;
   logic [DataWidth-1:0] read_mux;
   logic                 accept;
   logic                 core_busy;
   sdr_result_type       core_result;

   sdr_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .mode     (div_mode_ff),
      .dividend (dividend_ff),
      .divisor  (divisor_ff),
      .busy     (core_busy),
      .result   (core_result)
   );

   // A finished divide is written back before the next beat is taken.
   assign req_ready     = !start_ff && !core_busy && !core_result.valid &&
                          (!rsp_valid_ff || rsp_ready);
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // Write decode: merge the masked half and decide whether a divide starts.
   always_comb begin
      div_mode_in = div_mode_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      start_in    = 1'b0;
      if (accept && req_func == FUNC_WRITE) begin
         case (req_reg_select)
            SEL_CTRL: begin
               if (req_bit_mask[1:0] != 2'b00) begin
                  div_mode_in = req_write_data[1:0];
               end
               start_in = 1'b1;
            end
            SEL_NUM_LO: begin
               dividend_in[31:0] = merge_bits(dividend_ff[31:0], req_write_data,
                                              req_bit_mask);
               start_in = 1'b1;
            end
            SEL_NUM_HI: begin
               dividend_in[63:32] = merge_bits(dividend_ff[63:32], req_write_data,
                                               req_bit_mask);
               start_in = 1'b1;
            end
            SEL_DEN_LO: begin
               divisor_in[31:0] = merge_bits(divisor_ff[31:0], req_write_data,
                                             req_bit_mask);
               start_in = 1'b1;
            end
            SEL_DEN_HI: begin
               divisor_in[63:32] = merge_bits(divisor_ff[63:32], req_write_data,
                                              req_bit_mask);
               start_in = 1'b1;
            end
            default: begin
               start_in = 1'b0;
            end
         endcase
      end
   end

   // Read multiplexer; control shows the mode, the zero-divide flag and a clear busy bit.
   always_comb begin
      case (req_reg_select)
         SEL_CTRL:   read_mux = {16'b0, 1'b0, 1'b0, zero_div_ff, 11'b0, div_mode_ff};
         SEL_NUM_LO: read_mux = dividend_ff[31:0];
         SEL_NUM_HI: read_mux = dividend_ff[63:32];
         SEL_DEN_LO: read_mux = divisor_ff[31:0];
         SEL_DEN_HI: read_mux = divisor_ff[63:32];
         SEL_QUO_LO: read_mux = quot_ff[31:0];
         SEL_QUO_HI: read_mux = quot_ff[63:32];
         SEL_REM_LO: read_mux = rem_ff[31:0];
         SEL_REM_HI: read_mux = rem_ff[63:32];
         default:    read_mux = '0;
      endcase
   end

   // Register file and divide results.
   always_ff @(posedge clock) begin
      div_mode_ff <= div_mode_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      start_ff    <= start_in;
      if (core_result.valid) begin
         zero_div_ff <= core_result.zero_div;
         if (core_result.quot_we) begin
            quot_ff <= core_result.quot;
         end
         if (core_result.rem_we) begin
            rem_ff <= core_result.rem;
         end
      end
      if (reset) begin
         div_mode_ff <= '0;
         dividend_ff <= '0;
         divisor_ff  <= '0;
         quot_ff     <= '0;
         rem_ff      <= '0;
         zero_div_ff <= 1'b0;
         start_ff    <= 1'b0;
      end
   end

   // Response register: one beat per accepted request, zero data on writes.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= (req_func == FUNC_WRITE) ? '0 : read_mux;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end
   end

`include "signed_divider_regs_assert.svh"

   // No request is taken while a divide is pending or running.
   `SDR_ASSERT_IMPL(a_no_accept_busy, accept, !start_ff && !core_busy)
   // A starting write hands the divider a start pulse on the next cycle.
   `SDR_ASSERT_NEXT(a_start_follows, start_in, start_ff && !core_busy)
   // A completed divide always comes out of a running divider.
   `SDR_ASSERT_IMPL(a_result_from_busy, core_result.valid, $past(core_busy))
   // A divide result never lands while a request is accepted.
   `SDR_ASSERT_IMPL(a_result_not_accept, core_result.valid, !accept)

endmodule
